FILE: src/facility_parse_negotiate_assert.svh
// ----------------------------------------------------------------------------
// facility parse/negotiate assertion macros
// concurrent checks that compile away for synthesis
// ----------------------------------------------------------------------------
`ifndef FACILITY_PARSE_NEGOTIATE_ASSERT_SVH
`define FACILITY_PARSE_NEGOTIATE_ASSERT_SVH

`ifndef SYNTHESIS

// implication check, off while reset is high
`define FPN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen, off while reset is high
`define FPN_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define FPN_ASSERT(lbl, clk, rst, prop, msg)
`define FPN_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

FILE: src/fpn_pkg.sv
// ----------------------------------------------------------------------------
// fpn_pkg
// shared types and codes of the facilities parser and negotiator
// ----------------------------------------------------------------------------
package fpn_pkg;

   // parser phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CODE,
      PH_BODY
   } phase_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_REVERSE,
      CSR_THROUGHPUT,
      CSR_PKT_RX,
      CSR_PKT_TX,
      CSR_WIN_RX,
      CSR_WIN_TX
   } csr_index_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   // facility codes
   localparam logic [7:0] CODE_REVERSE    = 8'h01;
   localparam logic [7:0] CODE_THROUGHPUT = 8'h02;
   localparam logic [7:0] CODE_PACSIZE    = 8'h42;
   localparam logic [7:0] CODE_WINSIZE    = 8'h43;

   // element classes, top two bits of the code
   localparam logic [1:0] CLASS_A = 2'b00;
   localparam logic [1:0] CLASS_B = 2'b01;
   localparam logic [1:0] CLASS_C = 2'b10;
   localparam logic [1:0] CLASS_D = 2'b11;

   localparam logic [8:0] LEN_A = 9'd2;
   localparam logic [8:0] LEN_B = 9'd3;
   localparam logic [8:0] LEN_C = 9'd4;
   localparam logic [8:0] LEN_D = 9'd2;   // until its length byte arrives

   // seen mask bits
   localparam int unsigned MASK_REVERSE    = 0;
   localparam int unsigned MASK_THROUGHPUT = 1;
   localparam int unsigned MASK_PACSIZE    = 2;
   localparam int unsigned MASK_WINSIZE    = 3;

   // local settings
   typedef struct packed {
      logic       reverse;
      logic [7:0] throughput;
      logic [7:0] pkt_rx;
      logic [7:0] pkt_tx;
      logic [7:0] win_rx;
      logic [7:0] win_tx;
   } cfg_type;

   // one finished field, handed from parser to negotiator
   typedef struct packed {
      logic       malformed;
      logic [8:0] byte_count;
      logic [3:0] seen_mask;
      logic [7:0] win_tx;
      logic [7:0] win_rx;
      logic [7:0] pkt_tx;
      logic [7:0] pkt_rx;
      logic [7:0] throughput;
      logic       reverse;
   } rec_type;

   // result, first field in the highest bits
   typedef struct packed {
      logic       malformed;
      logic [8:0] consumed_bytes;
      logic [3:0] fac_mask;
      logic [7:0] neg_win_tx;
      logic [7:0] neg_win_rx;
      logic [7:0] neg_pkt_tx;
      logic [7:0] neg_pkt_rx;
      logic [7:0] neg_throughput;
      logic       neg_reverse;
      logic       rejected;
   } rsp_type;

   // queue status seen by the top level
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: src/fpn_front.sv
// ----------------------------------------------------------------------------
// fpn_front
// byte-wise walk of the facilities field, records peer requests
// ----------------------------------------------------------------------------
module fpn_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       fac_byte,
   input  logic             start_of_field,
   input  logic             queue_full,
   output logic             push,
   output fpn_pkg::rec_type push_rec
);
   import fpn_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] code_ff, code_in;
   logic [8:0] pos_ff, pos_in;
   logic [8:0] len_ff, len_in;
   logic       rev_ff, rev_in;
   logic [7:0] thr_ff, thr_in;
   logic [7:0] pi_ff, pi_in;
   logic [7:0] po_ff, po_in;
   logic [7:0] wi_ff, wi_in;
   logic [7:0] wo_ff, wo_in;
   logic [3:0] mask_ff, mask_in;
   logic [8:0] count_ff, count_in;

   logic       accept;
   logic [7:0] left_dec;
   logic       field_end;
   logic [8:0] pos_inc;
   logic [8:0] len_eff;
   logic       elem_done;
   logic       code_is_d;

   assign in_ready  = !queue_full;
   assign accept    = in_valid && in_ready;
   assign left_dec  = left_ff - 8'd1;
   assign field_end = (left_dec == 8'd0);
   assign pos_inc   = pos_ff + 9'd1;
   assign code_is_d = (code_ff[7:6] == CLASS_D);
   assign len_eff   = (code_is_d && pos_ff == 9'd1) ? ({1'b0, fac_byte} + 9'd2) : len_ff;
   assign elem_done = (pos_inc >= len_eff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (start_of_field) begin
            phase_in = (fac_byte == 8'd0) ? PH_IDLE : PH_CODE;
         end else begin
            case (phase_ff)
               PH_IDLE: phase_in = PH_IDLE;
               PH_CODE: phase_in = field_end ? PH_IDLE : PH_BODY;
               PH_BODY: begin
                  if (field_end) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = elem_done ? PH_CODE : PH_BODY;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // datapath and push
   always_comb begin
      left_in  = left_ff;
      code_in  = code_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      rev_in   = rev_ff;
      thr_in   = thr_ff;
      pi_in    = pi_ff;
      po_in    = po_ff;
      wi_in    = wi_ff;
      wo_in    = wo_ff;
      mask_in  = mask_ff;
      count_in = count_ff;
      push     = 1'b0;
      push_rec.malformed = 1'b0;
      if (accept) begin
         if (start_of_field) begin
            rev_in   = 1'b0;
            thr_in   = 8'd0;
            pi_in    = 8'd0;
            po_in    = 8'd0;
            wi_in    = 8'd0;
            wo_in    = 8'd0;
            mask_in  = 4'd0;
            count_in = 9'd1;
            left_in  = fac_byte;
            code_in  = 8'd0;
            pos_in   = 9'd0;
            len_in   = 9'd0;
            push     = (fac_byte == 8'd0);
         end else if (phase_ff != PH_IDLE) begin
            count_in = count_ff + 9'd1;
            left_in  = left_dec;
            if (phase_ff == PH_CODE) begin
               code_in = fac_byte;
               pos_in  = 9'd1;
               case (fac_byte[7:6])
                  CLASS_A: len_in = LEN_A;
                  CLASS_B: len_in = LEN_B;
                  CLASS_C: len_in = LEN_C;
                  CLASS_D: len_in = LEN_D;
                  default: len_in = LEN_A;
               endcase
               push_rec.malformed = 1'b1;
            end else begin
               if (code_ff == CODE_REVERSE && pos_ff == 9'd1) begin
                  rev_in = fac_byte[0];
                  mask_in[MASK_REVERSE] = 1'b1;
               end else if (code_ff == CODE_THROUGHPUT && pos_ff == 9'd1) begin
                  thr_in = fac_byte;
                  mask_in[MASK_THROUGHPUT] = 1'b1;
               end else if (code_ff == CODE_PACSIZE) begin
                  if (pos_ff == 9'd1) begin
                     pi_in = fac_byte;
                     mask_in[MASK_PACSIZE] = 1'b1;
                  end else if (pos_ff == 9'd2) begin
                     po_in = fac_byte;
                  end
               end else if (code_ff == CODE_WINSIZE) begin
                  if (pos_ff == 9'd1) begin
                     wi_in = fac_byte;
                     mask_in[MASK_WINSIZE] = 1'b1;
                  end else if (pos_ff == 9'd2) begin
                     wo_in = fac_byte;
                  end
               end
               len_in = len_eff;
               pos_in = pos_inc;
               push_rec.malformed = !elem_done;
            end
            push = field_end;
         end
      end
      push_rec.byte_count = count_in;
      push_rec.seen_mask  = mask_in;
      push_rec.reverse    = rev_in;
      push_rec.throughput = thr_in;
      push_rec.pkt_rx     = pi_in;
      push_rec.pkt_tx     = po_in;
      push_rec.win_rx     = wi_in;
      push_rec.win_tx     = wo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      code_ff  <= code_in;
      pos_ff   <= pos_in;
      len_ff   <= len_in;
      rev_ff   <= rev_in;
      thr_ff   <= thr_in;
      pi_ff    <= pi_in;
      po_ff    <= po_in;
      wi_ff    <= wi_in;
      wo_ff    <= wo_in;
      mask_ff  <= mask_in;
      count_ff <= count_in;
   end

endmodule

FILE: src/fpn_queue.sv
// ----------------------------------------------------------------------------
// fpn_queue
// short queue of finished fields between parser and negotiator
// ----------------------------------------------------------------------------
module fpn_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fpn_pkg::rec_type          push_rec,
   input  logic                      pop,
   output fpn_pkg::rec_type          head_rec,
   output fpn_pkg::queue_status_type status
);
   import fpn_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rec_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_rec     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

FILE: src/fpn_back.sv
// ----------------------------------------------------------------------------
// fpn_back
// negotiates a finished field against local settings, output register
// ----------------------------------------------------------------------------
module fpn_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             rec_valid,
   input  fpn_pkg::rec_type rec,
   output logic             pop,
   input  fpn_pkg::cfg_type cfg,
   output logic             out_valid,
   input  logic             out_ready,
   output fpn_pkg::rsp_type out_rsp
);
   import fpn_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    load;
   logic    rej;
   logic    pac_both;
   logic    win_both;

   assign load      = rec_valid && (!valid_ff || out_ready);
   assign pop       = load;
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

   assign rej      = rec.reverse && cfg.reverse;
   assign pac_both = (rec.pkt_rx != 8'd0) && (rec.pkt_tx != 8'd0);
   assign win_both = (rec.win_rx != 8'd0) && (rec.win_tx != 8'd0);

   always_comb begin
      rsp_in.rejected       = rej;
      rsp_in.neg_reverse    = rec.reverse;
      rsp_in.neg_throughput = cfg.throughput;
      rsp_in.neg_pkt_rx     = cfg.pkt_rx;
      rsp_in.neg_pkt_tx     = cfg.pkt_tx;
      rsp_in.neg_win_rx     = cfg.win_rx;
      rsp_in.neg_win_tx     = cfg.win_tx;
      rsp_in.fac_mask       = rec.seen_mask;
      rsp_in.consumed_bytes = rec.byte_count;
      rsp_in.malformed      = rec.malformed;
      if (!rej) begin
         // peer may only lower a value
         if (rec.throughput != 8'd0 && rec.throughput < cfg.throughput) begin
            rsp_in.neg_throughput = rec.throughput;
         end
         if (pac_both) begin
            if (rec.pkt_rx < cfg.pkt_rx) begin
               rsp_in.neg_pkt_rx = rec.pkt_rx;
            end
            if (rec.pkt_tx < cfg.pkt_tx) begin
               rsp_in.neg_pkt_tx = rec.pkt_tx;
            end
         end
         if (win_both) begin
            if (rec.win_rx < cfg.win_rx) begin
               rsp_in.neg_win_rx = rec.win_rx;
            end
            if (rec.win_tx < cfg.win_tx) begin
               rsp_in.neg_win_tx = rec.win_tx;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: src/facility_parse_negotiate.sv
// a field's result is registered into the field queue, then into the output register
// throughput: one byte per cycle while req_tready is high
// req_tready drops only while the field queue is full (QUEUE_DEPTH fields waiting)
// reset: synchronous, active high; clears parser phase, queue and output valid,
// and sets all local settings to zero; no clearing pass
// ----------------------------------------------------------------------------
// facility_parse_negotiate
// facilities field parser with negotiation of reverse charging, throughput,
// packet size and window size against local settings
// ----------------------------------------------------------------------------
module facility_parse_negotiate #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // fac_byte
   input  logic                           req_tuser,   // start_of_field
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rejected, neg_reverse, neg_throughput, neg_pkt_rx, neg_pkt_tx,
   // neg_win_rx, neg_win_tx, fac_mask, consumed_bytes, malformed
   output logic [55:0]                    rsp_tdata,
   // settings write port
   input  logic                           csr_we,
   input  logic [fpn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpn_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fpn_pkg::*;

`include "facility_parse_negotiate_assert.svh"

   cfg_type          cfg_ff, cfg_in;
   logic             push;
   rec_type          push_rec;
   rec_type          head_rec;
   queue_status_type q_status;
   logic             pop;
   rsp_type          rsp;

   // result-side views used by the checks
   logic             rej_out;
   logic             rev_seen;
   logic             thr_kept;
   logic             empty_bad;
   logic             thr_up;

   // local settings; user writes only while no transaction is in flight, unenforced
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REVERSE:    cfg_in.reverse    = csr_wdata[0];
            CSR_THROUGHPUT: cfg_in.throughput = csr_wdata;
            CSR_PKT_RX:     cfg_in.pkt_rx     = csr_wdata;
            CSR_PKT_TX:     cfg_in.pkt_tx     = csr_wdata;
            CSR_WIN_RX:     cfg_in.win_rx     = csr_wdata;
            CSR_WIN_TX:     cfg_in.win_tx     = csr_wdata;
            default:        cfg_in = cfg_ff;   // unused indexes ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: walks elements, hands one record per finished field
   fpn_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .fac_byte       (req_tdata),
      .start_of_field (req_tuser),
      .queue_full     (q_status.full),
      .push           (push),
      .push_rec       (push_rec)
   );

   // queue between the two halves so each can stall on its own
   fpn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .status   (q_status)
   );

   // back: negotiation and output register
   fpn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (!q_status.empty),
      .rec       (head_rec),
      .pop       (pop),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = rsp;

   assign rej_out   = rsp_tvalid && rsp.rejected;
   assign rev_seen  = rsp.neg_reverse && rsp.fac_mask[MASK_REVERSE];
   assign thr_kept  = (rsp.neg_throughput == cfg_ff.throughput);
   assign empty_bad = rsp_tvalid && rsp.malformed && (rsp.consumed_bytes == 9'd1);
   assign thr_up    = rsp_tvalid && (rsp.neg_throughput > cfg_ff.throughput);

   // a refused call must have seen the peer's reverse charging request
   `FPN_ASSERT(a_rej_seen, clock, reset, rej_out |-> rev_seen, "refused without reverse seen")
   // a refused call carries the local throughput unchanged
   `FPN_ASSERT(a_rej_thr, clock, reset, rej_out |-> thr_kept, "refused result altered throughput")
   // an empty field can never be malformed
   `FPN_ASSERT_NEVER(a_empty_bad, clock, reset, empty_bad, "malformed result on empty field")
   // negotiation only ever lowers the local value
   `FPN_ASSERT_NEVER(a_thr_raise, clock, reset, thr_up, "throughput raised above local")

endmodule

FILE: verif/facility_parse_negotiate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// facility_parse_negotiate_tb
// self-checking bench for the facilities parser and negotiator: a directed
// table of fields, then random well-formed, cut and broken fields under
// several local settings, every result checked against a typed expectation or a built-in predictor
// ----------------------------------------------------------------------------
module facility_parse_negotiate_tb;
   import fpn_pkg::*;

   localparam int QUIET_LIMIT = 2000;  // cycles with no transaction before giving up
   localparam int SETTLE      = 4;     // cycles allowed after the last result
   localparam int PHASE_BYTES = 215;   // parsed bytes per random settings phase

   typedef enum logic {
      ROW_BYTE,
      ROW_SETTINGS
   } row_kind_type;

   // one line of the directed table; a settings line writes reverse from
   // sof and throughput and every size register from b
   typedef struct {
      row_kind_type kind;
      logic [7:0]   b;
      logic         sof;
      logic         has_want;
      rsp_type      want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // fac_byte
   logic                   req_tuser;   // start_of_field
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // rejected, neg_reverse, neg_throughput, neg_pkt_rx, neg_pkt_tx,
   // neg_win_rx, neg_win_tx, fac_mask, consumed_bytes, malformed
   logic [55:0]            rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // predictor state, mirrors the parser of the block
   phase_type  fld_phase;
   logic [7:0] fld_left;
   logic [7:0] elem_code;
   logic [8:0] elem_pos;
   logic [8:0] elem_len;
   logic [3:0] seen_bits;
   logic [8:0] fld_count;
   cfg_type    peer_req;   // what the far end asked for
   cfg_type    own_cfg;    // our copy of the settings registers

   rsp_type      pending_results[$];   // negotiated results still owed by the block
   stim_row_type stim_rows[$];

   // the byte on the request side carries its own typed expectation
   logic    cur_has_want;
   rsp_type cur_want;

   bit calm;            // no idling on either side
   int quiet_cycles;
   int parsed_bytes;
   int mismatches;
   int n_results;
   int n_refused;
   int n_cut;
   int n_settings;

   rsp_type got_rsp;
   rsp_type want_rsp;
   rsp_type new_rsp;

   facility_parse_negotiate dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // negotiated values from the peer requests and our settings
   function automatic rsp_type negotiate_field(input logic bad);
      rsp_type r;
      logic    refuse;
      refuse = peer_req.reverse && own_cfg.reverse;
      r.rejected       = refuse;
      r.neg_reverse    = refuse ? own_cfg.reverse : peer_req.reverse;
      r.neg_throughput = own_cfg.throughput;
      r.neg_pkt_rx     = own_cfg.pkt_rx;
      r.neg_pkt_tx     = own_cfg.pkt_tx;
      r.neg_win_rx     = own_cfg.win_rx;
      r.neg_win_tx     = own_cfg.win_tx;
      // a refused call keeps our values untouched
      if (!refuse) begin
         if (peer_req.throughput != 8'd0 && peer_req.throughput < r.neg_throughput)
            r.neg_throughput = peer_req.throughput;
         // sizes only come down when the peer gave both directions
         if (peer_req.pkt_rx != 8'd0 && peer_req.pkt_tx != 8'd0) begin
            if (peer_req.pkt_rx < r.neg_pkt_rx)
               r.neg_pkt_rx = peer_req.pkt_rx;
            if (peer_req.pkt_tx < r.neg_pkt_tx)
               r.neg_pkt_tx = peer_req.pkt_tx;
         end
         if (peer_req.win_rx != 8'd0 && peer_req.win_tx != 8'd0) begin
            if (peer_req.win_rx < r.neg_win_rx)
               r.neg_win_rx = peer_req.win_rx;
            if (peer_req.win_tx < r.neg_win_tx)
               r.neg_win_tx = peer_req.win_tx;
         end
      end
      r.fac_mask       = seen_bits;
      r.consumed_bytes = fld_count;
      r.malformed      = bad;
      return r;
   endfunction

   // one accepted byte; returns 1 when the field closes and res holds its result
   function automatic bit take_fac_byte(input logic [7:0] b, input logic sof,
                                        output rsp_type res);
      logic [8:0] idx;
      res = '0;
      if (sof) begin
         // length byte: drop whatever was open and start again
         peer_req  = '0;
         seen_bits = '0;
         fld_count = 9'd1;
         fld_left  = b;
         elem_code = '0;
         elem_pos  = '0;
         elem_len  = '0;
         if (b == 8'd0) begin
            fld_phase = PH_IDLE;
            res = negotiate_field(1'b0);
            return 1'b1;
         end
         fld_phase = PH_CODE;
         return 1'b0;
      end
      // stray byte with no field open
      if (fld_phase == PH_IDLE)
         return 1'b0;

      fld_count = fld_count + 9'd1;
      if (fld_phase == PH_CODE) begin
         elem_code = b;
         case (b[7:6])
            CLASS_A: elem_len = LEN_A;
            CLASS_B: elem_len = LEN_B;
            CLASS_C: elem_len = LEN_C;
            default: elem_len = LEN_D;
         endcase
         elem_pos  = 9'd1;
         fld_phase = PH_BODY;
      end else begin
         idx = elem_pos;
         case (elem_code)
            CODE_REVERSE: if (idx == 9'd1) begin
               peer_req.reverse = b[0];
               seen_bits[MASK_REVERSE] = 1'b1;
            end
            CODE_THROUGHPUT: if (idx == 9'd1) begin
               peer_req.throughput = b;
               seen_bits[MASK_THROUGHPUT] = 1'b1;
            end
            CODE_PACSIZE: begin
               if (idx == 9'd1) begin
                  peer_req.pkt_rx = b;
                  seen_bits[MASK_PACSIZE] = 1'b1;
               end else if (idx == 9'd2) begin
                  peer_req.pkt_tx = b;
               end
            end
            CODE_WINSIZE: begin
               if (idx == 9'd1) begin
                  peer_req.win_rx = b;
                  seen_bits[MASK_WINSIZE] = 1'b1;
               end else if (idx == 9'd2) begin
                  peer_req.win_tx = b;
               end
            end
            default: ;
         endcase
         // class D carries its own length in the first body byte
         if (elem_code[7:6] == CLASS_D && idx == 9'd1)
            elem_len = {1'b0, b} + 9'd2;
         elem_pos = elem_pos + 9'd1;
         if (elem_pos >= elem_len)
            fld_phase = PH_CODE;
      end

      fld_left = fld_left - 8'd1;
      if (fld_left == 8'd0) begin
         // ending inside an element means the length was too short
         res = negotiate_field(fld_phase == PH_BODY);
         fld_phase = PH_IDLE;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   function automatic void check_field(input string fname, input logic [8:0] want,
                                       input logic [8:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
         mismatches++;
      end
   endfunction

   function automatic void compare_result(input rsp_type want, input rsp_type got);
      check_field("rejected", 9'(want.rejected), 9'(got.rejected));
      check_field("neg_reverse", 9'(want.neg_reverse), 9'(got.neg_reverse));
      check_field("neg_throughput", 9'(want.neg_throughput), 9'(got.neg_throughput));
      check_field("neg_pkt_rx", 9'(want.neg_pkt_rx), 9'(got.neg_pkt_rx));
      check_field("neg_pkt_tx", 9'(want.neg_pkt_tx), 9'(got.neg_pkt_tx));
      check_field("neg_win_rx", 9'(want.neg_win_rx), 9'(got.neg_win_rx));
      check_field("neg_win_tx", 9'(want.neg_win_tx), 9'(got.neg_win_tx));
      check_field("fac_mask", 9'(want.fac_mask), 9'(got.fac_mask));
      check_field("consumed_bytes", want.consumed_bytes, got.consumed_bytes);
      check_field("malformed", 9'(want.malformed), 9'(got.malformed));
   endfunction

   // both channels seen at the rising edge; the request side is taken first so a
   // result can never arrive ahead of its own prediction
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            quiet_cycles = 0;
            if (req_tuser || fld_phase != PH_IDLE)
               parsed_bytes++;
            if (take_fac_byte(req_tdata, req_tuser, new_rsp)) begin
               if (cur_has_want)
                  new_rsp = cur_want;
               pending_results.push_back(new_rsp);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            got_rsp = rsp_tdata;
            if (pending_results.size() == 0) begin
               $display("%0t: result with nothing expected, got %h", $time, got_rsp);
               mismatches++;
            end else begin
               want_rsp = pending_results.pop_front();
               compare_result(want_rsp, got_rsp);
               n_results++;
               n_refused += int'(want_rsp.rejected);
               n_cut     += int'(want_rsp.malformed);
            end
         end
      end
   end

   // a hung block ends the run
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // a peer value biased towards zero, one and the top
   function automatic logic [7:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h01;
         default: return 8'($urandom);
      endcase
   endfunction

   // typed result: throughput and every negotiated size the same value
   function automatic rsp_type outcome(input logic rej, input logic rev,
                                       input logic [7:0] neg, input logic [3:0] mask,
                                       input logic [8:0] consumed, input logic mal);
      return '{malformed: mal, consumed_bytes: consumed, fac_mask: mask,
               neg_win_tx: neg, neg_win_rx: neg, neg_pkt_tx: neg,
               neg_pkt_rx: neg, neg_throughput: neg, neg_reverse: rev,
               rejected: rej};
   endfunction

   function automatic void put_row(input row_kind_type k, input logic [7:0] b,
                                   input logic sof);
      stim_rows.push_back('{k, b, sof, 1'b0, '0});
   endfunction

   function automatic void put_want(input logic [7:0] b, input logic sof,
                                    input rsp_type want);
      stim_rows.push_back('{ROW_BYTE, b, sof, 1'b1, want});
   endfunction

   // one request transaction; starts and ends at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic sof, input logic has_want,
                            input rsp_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid   = 1'b1;
      req_tdata    = b;
      req_tuser    = sof;
      cur_has_want = has_want;
      cur_want     = want;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // sender holds off until every owed result is back, then a settling wait
   // for anything the block might still be chewing on
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // all six registers, one per cycle
   task automatic write_settings(input cfg_type c);
      csr_we    = 1'b1;
      csr_index = CSR_REVERSE;
      csr_wdata = {7'd0, c.reverse};
      @(negedge clock);
      csr_index = CSR_THROUGHPUT;
      csr_wdata = c.throughput;
      @(negedge clock);
      csr_index = CSR_PKT_RX;
      csr_wdata = c.pkt_rx;
      @(negedge clock);
      csr_index = CSR_PKT_TX;
      csr_wdata = c.pkt_tx;
      @(negedge clock);
      csr_index = CSR_WIN_RX;
      csr_wdata = c.win_rx;
      @(negedge clock);
      csr_index = CSR_WIN_TX;
      csr_wdata = c.win_tx;
      @(negedge clock);
      csr_we  = 1'b0;
      own_cfg = c;
      n_settings++;
   endtask

   // settings per random phase, extremes first
   function automatic cfg_type settings_for(input int p);
      cfg_type c;
      case (p)
         0:       c = {1'b0, {5{8'hFF}}};
         1:       c = {1'b1, {5{8'h00}}};
         2:       c = {1'b1, {5{8'hFF}}};
         3:       c = {1'b0, {5{8'h00}}};
         default: c = {1'($urandom), pick_value(), pick_value(), pick_value(),
                       pick_value(), pick_value()};
      endcase
      return c;
   endfunction

   // one random field: mostly well formed, the rest cut, padded, restarted or noise
   task automatic send_random_field();
      logic [7:0] body[$];
      int         n_elem;
      int         len;
      int         cut;
      int         r;
      int         n;
      r = $urandom_range(0, 99);
      n_elem = ($urandom_range(0, 49) == 0) ? 200 : $urandom_range(0, 6);
      while (body.size() < 255 && n_elem > 0) begin
         case ($urandom_range(0, 9))
            0: begin
               body.push_back(CODE_REVERSE);
               body.push_back(8'($urandom));
            end
            1: begin
               body.push_back(CODE_THROUGHPUT);
               body.push_back(pick_value());
            end
            2, 3: begin
               body.push_back(CODE_PACSIZE);
               body.push_back(pick_value());
               body.push_back(pick_value());
            end
            4, 5: begin
               body.push_back(CODE_WINSIZE);
               body.push_back(pick_value());
               body.push_back(pick_value());
            end
            // random codes, mostly ones the block does not know and skips by class length
            6: begin
               body.push_back({CLASS_A, 6'($urandom)});
               body.push_back(8'($urandom));
            end
            7: begin
               body.push_back({CLASS_B, 6'($urandom)});
               repeat (2) body.push_back(8'($urandom));
            end
            8: begin
               body.push_back({CLASS_C, 6'($urandom)});
               repeat (3) body.push_back(8'($urandom));
            end
            default: begin
               body.push_back({CLASS_D, 6'($urandom)});
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 4);
               body.push_back(8'(n));
               repeat (n) body.push_back(8'($urandom));
            end
         endcase
         n_elem--;
      end
      if (body.size() > 255)
         body = body[0:254];
      len = body.size();

      if (r < 12 && len > 1) begin
         // declared length ends early, usually inside an element
         len = $urandom_range(1, len - 1);
      end else if (r < 18 && len < 250) begin
         // declared length too long, tail parsed as elements
         repeat ($urandom_range(1, 5)) body.push_back(8'($urandom));
         len = body.size();
      end

      send_byte(8'(len), 1'b1, 1'b0, '0);
      // field dropped part way, the next length byte restarts the parse
      cut = (r >= 18 && r < 26 && len > 1) ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < cut; i++)
         send_byte(body[i], 1'b0, 1'b0, '0);
      // stray bytes with start_of_field low
      if (r >= 26 && r < 31)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
   endtask

   // result side: ready with random holds
   initial begin
      int gap;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int goal;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_REVERSE;
      csr_wdata    = '0;
      cur_has_want = 1'b0;
      cur_want     = '0;
      calm         = 1'b0;
      fld_phase    = PH_IDLE;
      fld_left     = '0;
      elem_code    = '0;
      elem_pos     = '0;
      elem_len     = '0;
      seen_bits    = '0;
      fld_count    = '0;
      peer_req     = '0;
      own_cfg      = '0;   // settings come out of reset at zero
      quiet_cycles = 0;
      parsed_bytes = 0;
      mismatches   = 0;
      n_results    = 0;
      n_refused    = 0;
      n_cut        = 0;
      n_settings   = 0;

      // directed table, reset settings first
      // empty field answers at once
      put_want(8'h00, 1'b1, outcome(1'b0, 1'b0, 8'h00, 4'h0, 9'd1, 1'b0));
      // stray byte with nothing open
      put_row(ROW_BYTE, 8'hA5, 1'b0);
      // all four known facilities, ours are zero so nothing moves
      put_row(ROW_BYTE, 8'h0A, 1'b1);
      put_row(ROW_BYTE, CODE_REVERSE, 1'b0);
      put_row(ROW_BYTE, 8'h01, 1'b0);
      put_row(ROW_BYTE, CODE_THROUGHPUT, 1'b0);
      put_row(ROW_BYTE, 8'h0A, 1'b0);
      put_row(ROW_BYTE, CODE_PACSIZE, 1'b0);
      put_row(ROW_BYTE, 8'h07, 1'b0);
      put_row(ROW_BYTE, 8'h08, 1'b0);
      put_row(ROW_BYTE, CODE_WINSIZE, 1'b0);
      put_row(ROW_BYTE, 8'h02, 1'b0);
      put_want(8'h03, 1'b0, outcome(1'b0, 1'b1, 8'h00, 4'hF, 9'd11, 1'b0));
      // reverse charging on our side, every size at the top
      put_row(ROW_SETTINGS, 8'hFF, 1'b1);
      // both sides want reverse charging: refused, our values unchanged
      put_row(ROW_BYTE, 8'h04, 1'b1);
      put_row(ROW_BYTE, CODE_REVERSE, 1'b0);
      put_row(ROW_BYTE, 8'h01, 1'b0);
      put_row(ROW_BYTE, CODE_THROUGHPUT, 1'b0);
      put_want(8'h05, 1'b0, outcome(1'b1, 1'b1, 8'hFF, 4'h3, 9'd5, 1'b0));
      // restart mid-element, then unknown class C and a class D cut by the length
      put_row(ROW_BYTE, 8'h03, 1'b1);
      put_row(ROW_BYTE, CODE_THROUGHPUT, 1'b0);
      put_row(ROW_BYTE, 8'h06, 1'b1);
      put_row(ROW_BYTE, {CLASS_C, 6'h00}, 1'b0);
      put_row(ROW_BYTE, 8'h11, 1'b0);
      put_row(ROW_BYTE, 8'h22, 1'b0);
      put_row(ROW_BYTE, 8'h33, 1'b0);
      put_row(ROW_BYTE, {CLASS_D, 6'h03}, 1'b0);
      put_want(8'h05, 1'b0, outcome(1'b0, 1'b0, 8'hFF, 4'h0, 9'd7, 1'b1));

      // single reset at the start
      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_SETTINGS) begin
            wait_idle();
            write_settings({stim_rows[i].sof, {5{stim_rows[i].b}}});
         end else begin
            send_byte(stim_rows[i].b, stim_rows[i].sof, stim_rows[i].has_want,
                      stim_rows[i].want);
         end
      end
      wait_idle();

      // random fields, one settings phase after another
      for (int p = 0; p < 6; p++) begin
         write_settings(settings_for(p));
         calm = (p == 4);
         goal = parsed_bytes + PHASE_BYTES;
         while (parsed_bytes < goal)
            send_random_field();
         // close any field left open before the settings change
         if (fld_phase != PH_IDLE)
            send_byte(8'h00, 1'b1, 1'b0, '0);
         wait_idle();
      end
      calm = 1'b0;

      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         mismatches++;
      end
      $display("parsed %0d bytes under %0d settings, %0d results checked",
               parsed_bytes, n_settings, n_results);
      $display("of those %0d refused on reverse charging and %0d cut short",
               n_refused, n_cut);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
